@@ hdl/ftm_pkg.sv @@
// shared constants and types for the frequency to note converter
package ftm_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int FRAC_BITS   = 8;
    localparam int IN_WIDTH    = 23;
    localparam int MSB_W       = $clog2(IN_WIDTH);
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    localparam int LOG_W       = 16;
    localparam int Y_W         = 32;
    localparam int ACC_W       = 24;
    localparam int SQ_STEPS    = ACC_W;
    localparam int STEP_W      = $clog2(SQ_STEPS);
    localparam int ACC_SHIFT   = ACC_W - LOG_W;

    localparam int C0_LOG2_Q16 = 198663;
    localparam int LOG_OFFSET  = FRAC_BITS * 65536 + C0_LOG2_Q16;
    localparam int FRAC12_W    = 26;

    localparam int NOTE_W      = 7;
    localparam int NOTE_MAX    = 127;
    localparam int NOTE_FULL_W = FRAC12_W - LOG_W;
    localparam int DEV_W       = 10;
    localparam int REM_W       = LOG_W + 1;
    localparam int DEV_SCALE   = 1000;
    localparam int DEV_PROD_W  = 28;
    localparam int HALF_Q16    = 32768;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    typedef struct packed {
        logic                  we;
        logic [TABLE_BITS-1:0] addr;
        logic [LOG_W-1:0]      data;
    } tbl_wr_t;

endpackage

@@ hdl/ftm_ram.sv @@
// generic single write port ram with registered read
module ftm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ftm_table_fill.sv @@
// builds the log2 fraction table after reset by repeated squaring
module ftm_table_fill (
    input  logic            aclk,
    input  logic            aresetn,
    output logic            busy,
    output ftm_pkg::tbl_wr_t wr
);

    import ftm_pkg::*;

    typedef enum logic {ST_FILL, ST_DONE} fill_state_t;

    fill_state_t             state_reg;
    logic [TABLE_BITS-1:0]   idx_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [Y_W-1:0]          y_reg;
    logic [ACC_W-1:0]        acc_reg;

    logic [Y_W-1:0]          y_cur;
    logic [ACC_W-1:0]        acc_cur;
    logic [2*Y_W-1:0]        prod;
    logic [Y_W:0]            sq;
    logic [Y_W-1:0]          y_next;
    logic [ACC_W-1:0]        acc_next;
    logic                    last_step;
    logic [ACC_W:0]          rounded;

    always_comb begin
        if (step_reg == '0) begin
            y_cur   = {1'b1, {(Y_W-1){1'b0}}} | (Y_W'(idx_reg) << (Y_W - 1 - TABLE_BITS));
            acc_cur = '0;
        end else begin
            y_cur   = y_reg;
            acc_cur = acc_reg;
        end
        prod = (2*Y_W)'(y_cur) * (2*Y_W)'(y_cur);
        sq   = prod[2*Y_W-1:Y_W-1];
        if (sq[Y_W]) begin
            y_next = sq[Y_W:1];
        end else begin
            y_next = sq[Y_W-1:0];
        end
        acc_next  = {acc_cur[ACC_W-2:0], sq[Y_W]};
        last_step = (step_reg == STEP_W'(SQ_STEPS - 1));
        rounded   = ((ACC_W+1)'(acc_next) + (ACC_W+1)'(1 << (ACC_SHIFT - 1))) >> ACC_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_FILL: begin
                    y_reg   <= y_next;
                    acc_reg <= acc_next;
                    if (last_step) begin
                        step_reg <= '0;
                        idx_reg  <= idx_reg + 1'b1;
                        if (idx_reg == '1) begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_DONE;
                end
                default: begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    assign busy    = (state_reg == ST_FILL);
    assign wr.we   = (state_reg == ST_FILL) && last_step;
    assign wr.addr = idx_reg;
    assign wr.data = rounded[LOG_W-1:0];

endmodule

@@ hdl/ftm_note_round.sv @@
// rounds the fractional note, derives the deviation and saturates the note
module ftm_note_round (
    input  logic                            zero,
    input  logic [ftm_pkg::FRAC12_W-1:0]    frac12,
    output logic [ftm_pkg::NOTE_W-1:0]      note_number,
    output logic [ftm_pkg::DEV_W-1:0]       deviation_tenths,
    output logic                            out_of_range
);

    import ftm_pkg::*;

    logic signed [FRAC12_W-1:0]    biased;
    logic signed [NOTE_FULL_W-1:0] note_full;
    logic signed [REM_W-1:0]       rem;
    logic signed [DEV_PROD_W-1:0]  dev_prod;
    logic signed [DEV_PROD_W-1:0]  dev_biased;
    logic signed [DEV_PROD_W-1:0]  dev_full;

    always_comb begin
        biased     = $signed(frac12 + FRAC12_W'(HALF_Q16));
        note_full  = biased[FRAC12_W-1:LOG_W];
        rem        = $signed({1'b0, biased[LOG_W-1:0]}) - $signed(REM_W'(HALF_Q16));
        dev_prod   = DEV_PROD_W'(rem) * $signed(DEV_PROD_W'(DEV_SCALE));
        dev_biased = dev_prod + $signed(DEV_PROD_W'(HALF_Q16));
        dev_full   = dev_biased >>> LOG_W;

        if (zero) begin
            note_number      = '0;
            deviation_tenths = '0;
            out_of_range     = 1'b1;
        end else begin
            deviation_tenths = dev_full[DEV_W-1:0];
            if (note_full < 0) begin
                note_number  = '0;
                out_of_range = 1'b1;
            end else if (note_full > $signed(NOTE_FULL_W'(NOTE_MAX))) begin
                note_number  = NOTE_W'(NOTE_MAX);
                out_of_range = 1'b1;
            end else begin
                note_number  = note_full[NOTE_W-1:0];
                out_of_range = 1'b0;
            end
        end
    end

endmodule

@@ hdl/freq_to_midi_note.sv @@
// top level: frequency in hertz to nearest midi note and deviation
//
// After reset the block builds its 1024-entry log2 fraction table in a ram,
// one entry at a time through a single squaring multiplier, and s_tready
// stays low until the table is complete. From then on it takes one frequency
// per cycle while the output is not stalled by m_tready. Each result passes
// through registered steps in order: the leading-one search and table read,
// the log2 sum and scale by twelve, then rounding, the deviation product and
// saturation into the output register. Results come out in input order;
// m_tuser flags a zero input or a note outside 0..127.
module freq_to_midi_note (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ftm_pkg::S_TDATA_W-1:0]    s_tdata,   // [22:0] frequency_q8
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ftm_pkg::M_TDATA_W-1:0]    m_tdata,   // [6:0] note_number, [16:7] deviation_tenths
    output logic                             m_tuser    // [0] out_of_range
);

    import ftm_pkg::*;

    tbl_wr_t                 tbl_wr;
    logic                    filling;

    logic [IN_WIDTH-1:0]     freq;
    logic [MSB_W-1:0]        msb;
    logic [IN_WIDTH-1:0]     norm;
    logic [TABLE_BITS-1:0]   idx;
    logic                    in_zero;
    logic                    accept;
    logic [LOG_W-1:0]        log_frac;

    logic                    v1_reg;
    logic                    zero1_reg;
    logic [MSB_W-1:0]        msb1_reg;
    logic                    v2_reg;
    logic                    zero2_reg;
    logic [FRAC12_W-1:0]     frac12_reg;
    logic                    mv_reg;
    logic [NOTE_W-1:0]       note_reg;
    logic [DEV_W-1:0]        dev_reg;
    logic                    oor_reg;

    logic                    rdy1;
    logic                    rdy2;
    logic                    rdy3;
    logic [FRAC12_W-1:0]     lg;
    logic [FRAC12_W-1:0]     frac12_next;

    logic [NOTE_W-1:0]       note_c;
    logic [DEV_W-1:0]        dev_c;
    logic                    oor_c;

    ftm_table_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (filling),
        .wr      (tbl_wr)
    );

    ftm_ram #(
        .WIDTH (LOG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_log_ram (
        .aclk  (aclk),
        .we    (tbl_wr.we),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .re    (accept),
        .raddr (idx),
        .rdata (log_frac)
    );

    // leading one and normalized mantissa
    always_comb begin
        freq = s_tdata[IN_WIDTH-1:0];
        msb  = '0;
        for (int i = 0; i < IN_WIDTH; i++) begin
            if (freq[i]) begin
                msb = MSB_W'(i);
            end
        end
        in_zero = (freq == '0);
        norm    = freq << (MSB_W'(IN_WIDTH - 1) - msb);
        idx     = norm[IN_WIDTH-2 -: TABLE_BITS];
    end

    assign rdy3     = !mv_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !filling && rdy1;
    assign accept   = s_tvalid && s_tready;

    // log2 in q16 minus log2 of c0, times twelve
    always_comb begin
        lg = (FRAC12_W'(msb1_reg) << LOG_W) + FRAC12_W'(log_frac) - FRAC12_W'(LOG_OFFSET);
        frac12_next = (lg << 3) + (lg << 2);
    end

    ftm_note_round u_round (
        .zero             (zero2_reg),
        .frac12           (frac12_reg),
        .note_number      (note_c),
        .deviation_tenths (dev_c),
        .out_of_range     (oor_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= accept;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                mv_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            zero1_reg <= in_zero;
            msb1_reg  <= msb;
        end
        if (rdy2 && v1_reg) begin
            zero2_reg  <= zero1_reg;
            frac12_reg <= frac12_next;
        end
        if (rdy3 && v2_reg) begin
            note_reg <= note_c;
            dev_reg  <= dev_c;
            oor_reg  <= oor_c;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(M_TDATA_W - NOTE_W - DEV_W){1'b0}}, dev_reg, note_reg};
    assign m_tuser  = oor_reg;

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the frequency to midi note converter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftm_pkg::*;

    typedef struct packed {
        logic [NOTE_W-1:0] note_number;
        logic [DEV_W-1:0]  deviation_tenths;
        logic              out_of_range;
    } note_result_t;

    localparam int IDLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 600;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    logic [IN_WIDTH-1:0] freq_q[$];
    note_result_t        note_expect_q[$];
    int                  errors    = 0;
    int                  send_gap  = 0;
    int                  recv_gap  = 0;
    int                  idle_cnt  = 0;
    int                  cycle_cnt = 0;

    freq_to_midi_note u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // fraction of log2(1 + idx/2^TABLE_BITS) in q16, by repeated squaring
    function automatic logic [LOG_W:0] log2_frac_q16(input logic [TABLE_BITS-1:0] idx);
        longint unsigned y;
        logic [ACC_W-1:0] acc;
        logic [ACC_W:0]   rounded;
        y = (64'd1 << 31) + (64'(idx) << (31 - TABLE_BITS));
        acc = '0;
        for (int k = 0; k < ACC_W; k++) begin
            y = (y * y) >> 31;
            acc = acc << 1;
            if (y >= (64'd2 << 31)) begin
                acc[0] = 1'b1;
                y = y >> 1;
            end
        end
        rounded = {1'b0, acc} + (ACC_W + 1)'(128);
        return rounded[ACC_W:ACC_SHIFT];
    endfunction

    function automatic note_result_t predict_note(input logic [IN_WIDTH-1:0] freq);
        note_result_t        r;
        int                  lead;
        logic [IN_WIDTH-1:0] below;
        logic [TABLE_BITS-1:0] idx;
        longint              lg;
        longint              frac12;
        longint              note;
        longint              dev;
        r = '0;
        if (freq == '0) begin
            r.out_of_range = 1'b1;
            return r;
        end
        lead = 0;
        for (int p = 0; p < IN_WIDTH; p++)
            if (freq[p])
                lead = p;
        below = freq & ~(IN_WIDTH'(1) << lead);
        if (lead >= TABLE_BITS)
            idx = TABLE_BITS'(below >> (lead - TABLE_BITS));
        else
            idx = TABLE_BITS'(below << (TABLE_BITS - lead));
        lg = longint'(lead - FRAC_BITS) * 65536 + longint'(log2_frac_q16(idx));
        frac12 = 12 * (lg - C0_LOG2_Q16);
        note = (frac12 + HALF_Q16) >>> 16;
        dev = ((frac12 - note * 65536) * DEV_SCALE + HALF_Q16) >>> 16;
        r.deviation_tenths = dev[DEV_W-1:0];
        if (note < 0) begin
            r.note_number = '0;
            r.out_of_range = 1'b1;
        end else if (note > NOTE_MAX) begin
            r.note_number = NOTE_W'(NOTE_MAX);
            r.out_of_range = 1'b1;
        end else begin
            r.note_number = note[NOTE_W-1:0];
        end
        return r;
    endfunction

    // mostly back to back, some short pauses, a few long ones, calm stretches
    function automatic int pick_gap();
        int roll;
        if ((cycle_cnt % 400) < 100)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_WIDTH-1:0] random_freq();
        int kind;
        int lead;
        logic [IN_WIDTH-1:0] bits;
        kind = $urandom_range(99);
        bits = IN_WIDTH'($urandom);
        if (kind < 40) begin
            return bits;
        end else if (kind < 85) begin
            lead = $urandom_range(IN_WIDTH - 1);
            return (IN_WIDTH'(1) << lead) | (bits & ((IN_WIDTH'(1) << lead) - 1));
        end else if (kind < 95) begin
            return IN_WIDTH'($urandom_range(27 * 256, 4200 * 256));
        end else begin
            return IN_WIDTH'($urandom_range(0, 4096));
        end
    endfunction

    // driver: presents pending frequencies, records expectations on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                note_expect_q.push_back(predict_note(s_tdata[IN_WIDTH-1:0]));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (freq_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(freq_q.pop_front());
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transfer with the oldest expectation
    always @(posedge aclk) begin
        note_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (note_expect_q.size() == 0) begin
                    $error("unexpected result transfer: m_tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = note_expect_q.pop_front();
                    if (m_tdata[NOTE_W-1:0] !== want.note_number) begin
                        $error("note_number: expected %0d, actual %0d",
                               want.note_number, m_tdata[NOTE_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[NOTE_W+DEV_W-1:NOTE_W] !== want.deviation_tenths) begin
                        $error("deviation_tenths: expected %0d, actual %0d",
                               $signed(want.deviation_tenths),
                               $signed(m_tdata[NOTE_W+DEV_W-1:NOTE_W]));
                        errors++;
                    end
                    if (m_tuser !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, actual %0d",
                               want.out_of_range, m_tuser);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer; covers the table build after reset
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        // zero, tiny values with padded table index, powers of two, range edges
        freq_q.push_back(23'd0);
        freq_q.push_back(23'd1);
        freq_q.push_back(23'd2);
        freq_q.push_back(23'd3);
        freq_q.push_back(23'd255);
        freq_q.push_back(23'd256);
        freq_q.push_back(23'd513);
        freq_q.push_back(23'd1023);
        freq_q.push_back(23'd1024);
        freq_q.push_back(23'd2033);
        freq_q.push_back(23'd2093);
        freq_q.push_back(23'd66977);
        freq_q.push_back(23'd112640);
        freq_q.push_back(23'd3211226);
        freq_q.push_back(23'd3300000);
        freq_q.push_back(23'd4194303);
        freq_q.push_back(23'd4194304);
        freq_q.push_back(23'h555555);
        freq_q.push_back(23'h2AAAAA);
        freq_q.push_back(23'd7000000);
        freq_q.push_back(23'd8388607);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            freq_q.push_back(random_freq());

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (freq_q.size() != 0 || s_tvalid || note_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && note_expect_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ftm_pkg.sv
hdl/ftm_ram.sv
hdl/ftm_table_fill.sv
hdl/ftm_note_round.sv
hdl/freq_to_midi_note.sv
tb/tb.sv
